@@ rtl/goi_pkg.sv @@
// Shared constants, types and command and status structs of the gyroscope orientation integrator.
package goi_pkg;

    localparam int MATRIX_FRAC_BITS = 30;
    localparam int CORDIC_STEPS     = 24;
    localparam int ATAN_DEPTH       = 30;

    localparam int WRAP_MOD  = 411774832;
    localparam int WRAP_HALF = 205887416;
    localparam longint WRAP_T32 = 64'h1_0000_0000 % 64'(WRAP_MOD);
    localparam int WRAP_K    = int'((WRAP_T32 * WRAP_T32) % 64'(WRAP_MOD));
    localparam int DIV_Q     = 1000;

    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] THETA_BIAS  = 35'sd4294967296;
    localparam logic signed [63:0] NUM_BIAS    = 64'sd4294967296000 + 64'sd500;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

    localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_MUL, DP_ACC, DP_DIVP, DP_DIV, DP_FIXR,
        DP_THETA, DP_CORDIC, DP_TRIG, DP_WRITE, DP_COPY, DP_EMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        PH_RATE, PH_XY, PH_AZ, PH_RM
    } phase_t;

    typedef struct packed {
        dp_op_t     op;
        phase_t     phase;
        logic [1:0] axis;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic [4:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

@@ rtl/gyro_orientation_integrator.sv @@
// Top level of the gyroscope orientation integrator.
// Integrates gyroscope beats (operation 0: Q16.16 rates and a ms timestamp)
// into a Q2.30 rotation matrix; a take beat (operation 1) returns the three
// rows as three output beats, last set on row 2, and resets the matrix to
// identity. The first sample after reset only records its timestamp. Each
// later sample occupies the block for, per axis, one multiply for rate*dt,
// two radix-16 restoring divisions (the wrap modulo 2*pi and the divide by
// 1000) and the CORDIC loop; then 27 sums of three products, one per
// matrix element, through the single shared multiplier. A take emits one
// row each time the output register is free. Results sit in an output
// register, so a waiting result does not block the next input beat.
module gyro_orientation_integrator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic signed [31:0]  rate_x,
    input  logic signed [31:0]  rate_y,
    input  logic signed [31:0]  rate_z,
    input  logic [31:0]         stamp_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          row_index,
    output logic signed [31:0]  col_0,
    output logic signed [31:0]  col_1,
    output logic signed [31:0]  col_2,
    output logic                last
);
    import goi_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    goi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic and matrix store
    goi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operation (operation),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .stamp_ms  (stamp_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_index (row_index),
        .col_0     (col_0),
        .col_1     (col_1),
        .col_2     (col_2),
        .last      (last)
    );

endmodule

@@ rtl/goi_dp.sv @@
// Datapath: divider, CORDIC, shared multiplier and matrix registers.
module goi_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  goi_pkg::cmd_t       cmd,
    output goi_pkg::sts_t       sts,
    input  logic                operation,
    input  logic signed [31:0]  rate_x,
    input  logic signed [31:0]  rate_y,
    input  logic signed [31:0]  rate_z,
    input  logic [31:0]         stamp_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          row_index,
    output logic signed [31:0]  col_0,
    output logic signed [31:0]  col_1,
    output logic signed [31:0]  col_2,
    output logic                last
);
    import goi_pkg::*;

    localparam int SH_R = 30 - MATRIX_FRAC_BITS;
    localparam logic signed [63:0] RND_R = (SH_R == 0) ? 64'sd0 : (64'sd1 <<< (SH_R - 1));
    localparam logic signed [63:0] RND_F = 64'sd1 <<< (MATRIX_FRAC_BITS - 1);
    localparam logic signed [63:0] LIM   = 64'sd1 <<< MATRIX_FRAC_BITS;
    localparam logic signed [31:0] ONE_F = 32'sd1 <<< MATRIX_FRAC_BITS;

    logic signed [31:0] rate_reg [3];
    logic [31:0]        dt_reg, prev_stamp_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic [63:0]        div_d_reg;
    logic [29:0]        div_r_reg;
    logic               div_sel_reg, p_neg_reg;
    logic signed [34:0] cz_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic               neg_reg;
    logic signed [31:0] sin_reg [3];
    logic signed [31:0] cos_reg [3];
    logic signed [31:0] a_mat_reg [9];
    logic signed [31:0] r_mat_reg [9];
    logic signed [31:0] orient_reg [9];
    logic               out_valid_reg, last_reg;
    logic [1:0]         row_index_reg;
    logic signed [31:0] col_reg [3];

    function automatic logic signed [31:0] rot_x(input logic [3:0] e,
                                                 input logic signed [31:0] s,
                                                 input logic signed [31:0] c);
        logic signed [31:0] v;
        case (e) inside
            4'd0:       v = ONE_Q30;
            4'd4, 4'd8: v = c;
            4'd5:       v = -s;
            4'd7:       v = s;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rot_y(input logic [3:0] e,
                                                 input logic signed [31:0] s,
                                                 input logic signed [31:0] c);
        logic signed [31:0] v;
        case (e) inside
            4'd0, 4'd8: v = c;
            4'd2:       v = s;
            4'd6:       v = -s;
            4'd4:       v = ONE_Q30;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rot_z(input logic [3:0] e,
                                                 input logic signed [31:0] s,
                                                 input logic signed [31:0] c);
        logic signed [31:0] v;
        case (e) inside
            4'd0, 4'd4: v = c;
            4'd1:       v = -s;
            4'd3:       v = s;
            4'd8:       v = ONE_Q30;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // operand select and multiply
    logic [3:0]         e_a, e_b, e_w;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_full;

    assign e_a = 4'(cmd.row) * 4'd3 + 4'(cmd.k);
    assign e_b = 4'(cmd.k) * 4'd3 + 4'(cmd.col);
    assign e_w = 4'(cmd.row) * 4'd3 + 4'(cmd.col);

    always_comb
    begin
        case (cmd.phase)
            PH_RATE:
            begin
                op_a = 33'(rate_reg[cmd.axis]);
                op_b = $signed({1'b0, dt_reg});
            end
            PH_XY:
            begin
                op_a = 33'(rot_x(e_a, sin_reg[0], cos_reg[0]));
                op_b = 33'(rot_y(e_b, sin_reg[1], cos_reg[1]));
            end
            PH_AZ:
            begin
                op_a = 33'(a_mat_reg[e_a]);
                op_b = 33'(rot_z(e_b, sin_reg[2], cos_reg[2]));
            end
            default:
            begin
                op_a = 33'(r_mat_reg[e_a]);
                op_b = 33'(orient_reg[e_b]);
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    // four restoring steps per cycle
    logic [29:0] dvs, dv_r, dv_sh;
    logic [63:0] dv_d;

    assign dvs = div_sel_reg ? 30'(DIV_Q) : 30'(WRAP_MOD);

    always_comb
    begin
        dv_r = div_r_reg;
        dv_d = div_d_reg;
        dv_sh = '0;
        for (int b = 0; b < 4; b++)
        begin
            dv_sh = {dv_r[28:0], dv_d[63]};
            dv_d  = {dv_d[62:0], 1'b0};
            if (dv_sh >= dvs)
            begin
                dv_r    = dv_sh - dvs;
                dv_d[0] = 1'b1;
            end
            else
            begin
                dv_r = dv_sh;
            end
        end
    end

    // remainder to signed wrapped angle numerator
    logic signed [31:0] fx_t;
    logic signed [63:0] fx_num;

    always_comb
    begin
        fx_t = $signed({2'b00, div_r_reg});
        if (p_neg_reg)
            fx_t = fx_t - 32'(WRAP_K);
        if (fx_t < 0)
            fx_t = fx_t + 32'(WRAP_MOD);
        if (fx_t > 32'(WRAP_HALF))
            fx_t = fx_t - 32'(WRAP_MOD);
        fx_num = (64'(fx_t) <<< 14) + NUM_BIAS;
    end

    // quadrant fold
    logic signed [34:0] th, th_f;
    logic               th_neg;

    always_comb
    begin
        th     = $signed({1'b0, div_d_reg[33:0]}) - THETA_BIAS;
        th_f   = th;
        th_neg = 1'b0;
        if (th > HALF_PI_Q30)
        begin
            th_f   = th - PI_Q30;
            th_neg = 1'b1;
        end
        else if (th < -HALF_PI_Q30)
        begin
            th_f   = th + PI_Q30;
            th_neg = 1'b1;
        end
    end

    // CORDIC iteration
    logic signed [32:0] cr_dx, cr_dy;
    logic signed [34:0] cr_at;

    assign cr_dx = cy_reg >>> cmd.cnt;
    assign cr_dy = cx_reg >>> cmd.cnt;
    assign cr_at = $signed({3'b000, ATAN_Q30[cmd.cnt]});

    // rounding of a finished sum of products
    logic signed [63:0] r30, rr, ro;
    logic signed [31:0] wr_r, wr_o;

    always_comb
    begin
        r30 = (acc_reg + (64'sd1 <<< 29)) >>> 30;
        rr  = (r30 + RND_R) >>> SH_R;
        if (rr > LIM)
            rr = LIM;
        if (rr < -LIM)
            rr = -LIM;
        wr_r = rr[31:0];
        ro = (acc_reg + RND_F) >>> MATRIX_FRAC_BITS;
        if (ro > 64'sd2147483647)
            wr_o = 32'sh7FFFFFFF;
        else if (ro < -64'sd2147483648)
            wr_o = 32'sh80000000;
        else
            wr_o = ro[31:0];
    end

    logic signed [32:0] trig_s, trig_c;
    assign trig_s = neg_reg ? -cy_reg : cy_reg;
    assign trig_c = neg_reg ? -cx_reg : cx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_stamp_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int n = 0; n < 9; n++)
                orient_reg[n] <= (n % 4 == 0) ? ONE_F : 32'sd0;
        end
        else
        begin
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.op == DP_LOAD && !operation)
                prev_stamp_reg <= stamp_ms;

            if (cmd.op == DP_COPY)
                orient_reg <= a_mat_reg;

            if (cmd.op == DP_EMIT)
            begin
                if (cmd.row == 2'd2)
                begin
                    for (int n = 0; n < 9; n++)
                        orient_reg[n] <= (n % 4 == 0) ? ONE_F : 32'sd0;
                end
                else
                begin
                    for (int n = 0; n < 6; n++)
                        orient_reg[n] <= orient_reg[n + 3];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                rate_reg[0] <= rate_x;
                rate_reg[1] <= rate_y;
                rate_reg[2] <= rate_z;
                dt_reg      <= stamp_ms - prev_stamp_reg;
            end
            DP_MUL:
            begin
                prod_reg <= prod_full[63:0];
                if (cmd.k == 2'd0)
                    acc_reg <= '0;
                else
                    acc_reg <= acc_reg + prod_reg;
            end
            DP_ACC:
                acc_reg <= acc_reg + prod_reg;
            DP_DIVP:
            begin
                div_d_reg   <= prod_reg;
                div_r_reg   <= '0;
                div_sel_reg <= 1'b0;
                p_neg_reg   <= prod_reg[63];
            end
            DP_DIV:
            begin
                div_d_reg <= dv_d;
                div_r_reg <= dv_r;
            end
            DP_FIXR:
            begin
                div_d_reg   <= fx_num;
                div_r_reg   <= '0;
                div_sel_reg <= 1'b1;
            end
            DP_THETA:
            begin
                cx_reg  <= CORDIC_GAIN;
                cy_reg  <= '0;
                cz_reg  <= th_f;
                neg_reg <= th_neg;
            end
            DP_CORDIC:
            begin
                if (!cz_reg[34])
                begin
                    cx_reg <= cx_reg - cr_dx;
                    cy_reg <= cy_reg + cr_dy;
                    cz_reg <= cz_reg - cr_at;
                end
                else
                begin
                    cx_reg <= cx_reg + cr_dx;
                    cy_reg <= cy_reg - cr_dy;
                    cz_reg <= cz_reg + cr_at;
                end
            end
            DP_TRIG:
            begin
                sin_reg[cmd.axis] <= trig_s[31:0];
                cos_reg[cmd.axis] <= trig_c[31:0];
            end
            DP_WRITE:
            begin
                case (cmd.phase)
                    PH_XY:   a_mat_reg[e_w] <= r30[31:0];
                    PH_AZ:   r_mat_reg[e_w] <= wr_r;
                    PH_RM:   a_mat_reg[e_w] <= wr_o;
                    default: ;
                endcase
            end
            DP_EMIT:
            begin
                row_index_reg <= cmd.row;
                last_reg      <= (cmd.row == 2'd2);
                col_reg[0]    <= orient_reg[0];
                col_reg[1]    <= orient_reg[1];
                col_reg[2]    <= orient_reg[2];
            end
            default: ;
        endcase
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign row_index    = row_index_reg;
    assign last         = last_reg;
    assign col_0        = col_reg[0];
    assign col_1        = col_reg[1];
    assign col_2        = col_reg[2];

endmodule

@@ rtl/goi_ctrl.sv @@
// Controller: sequences the datapath for samples and takes.
module goi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          operation,
    input  goi_pkg::sts_t sts,
    output goi_pkg::cmd_t cmd
);
    import goi_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RMUL  = 14'b00000000000010,
        S_DIVP  = 14'b00000000000100,
        S_DIVM  = 14'b00000000001000,
        S_FIXR  = 14'b00000000010000,
        S_DIVQ  = 14'b00000000100000,
        S_THETA = 14'b00000001000000,
        S_CORD  = 14'b00000010000000,
        S_TRIG  = 14'b00000100000000,
        S_MAC   = 14'b00001000000000,
        S_ACC   = 14'b00010000000000,
        S_WRITE = 14'b00100000000000,
        S_COPY  = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic       first_reg, first_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] k_reg, k_next;
    logic [4:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd        = '{op: DP_NOP, phase: phase_reg, axis: axis_reg, row: row_reg,
                       col: col_reg, k: k_reg, cnt: cnt_reg};
        in_stall   = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = DP_LOAD;
                    if (operation)
                    begin
                        row_next   = 2'd0;
                        state_next = S_EMIT;
                    end
                    else if (first_reg)
                    begin
                        first_next = 1'b0;
                    end
                    else
                    begin
                        axis_next  = 2'd0;
                        phase_next = PH_RATE;
                        k_next     = 2'd0;
                        state_next = S_RMUL;
                    end
                end
            end
            S_RMUL:
            begin
                cmd.op     = DP_MUL;
                state_next = S_DIVP;
            end
            S_DIVP:
            begin
                cmd.op     = DP_DIVP;
                cnt_next   = '0;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.op   = DP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = S_FIXR;
            end
            S_FIXR:
            begin
                cmd.op     = DP_FIXR;
                cnt_next   = '0;
                state_next = S_DIVQ;
            end
            S_DIVQ:
            begin
                cmd.op   = DP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = S_THETA;
            end
            S_THETA:
            begin
                cmd.op     = DP_THETA;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                cmd.op   = DP_CORDIC;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = S_TRIG;
            end
            S_TRIG:
            begin
                cmd.op = DP_TRIG;
                if (axis_reg == 2'd2)
                begin
                    phase_next = PH_XY;
                    row_next   = 2'd0;
                    col_next   = 2'd0;
                    k_next     = 2'd0;
                    state_next = S_MAC;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_RMUL;
                end
            end
            S_MAC:
            begin
                cmd.op = DP_MUL;
                if (k_reg == 2'd2)
                    state_next = S_ACC;
                else
                    k_next = k_reg + 2'd1;
            end
            S_ACC:
            begin
                cmd.op     = DP_ACC;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.op     = DP_WRITE;
                k_next     = 2'd0;
                state_next = S_MAC;
                if (col_reg != 2'd2)
                begin
                    col_next = col_reg + 2'd1;
                end
                else
                begin
                    col_next = 2'd0;
                    if (row_reg != 2'd2)
                    begin
                        row_next = row_reg + 2'd1;
                    end
                    else
                    begin
                        row_next = 2'd0;
                        if (phase_reg == PH_RM)
                            state_next = S_COPY;
                        else
                            phase_next = (phase_reg == PH_XY) ? PH_AZ : PH_RM;
                    end
                end
            end
            S_COPY:
            begin
                cmd.op     = DP_COPY;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op = DP_EMIT;
                    if (row_reg == 2'd2)
                        state_next = S_IDLE;
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b1;
            phase_reg <= PH_RATE;
            axis_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/goi_chk.sv @@
// Port-level checker for the orientation integrator, bound to the top level.
module goi_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                operation,
    input logic signed [31:0]  rate_x,
    input logic signed [31:0]  rate_y,
    input logic signed [31:0]  rate_z,
    input logic [31:0]         stamp_ms,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          row_index,
    input logic signed [31:0]  col_0,
    input logic signed [31:0]  col_1,
    input logic signed [31:0]  col_2,
    input logic                last
);

    // last marks row 2 and only row 2
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (row_index == 2'd2)))
        else $error("last does not match row 2");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_index != 2'd3))
        else $error("row index out of range");

    // a take beat busies the input side while rows are emitted
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation) |=> in_stall)
        else $error("input accepted during take");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(row_index) && $stable(col_0)
            && $stable(col_1) && $stable(col_2) && $stable(last)))
        else $error("stalled output beat changed");

endmodule

bind gyro_orientation_integrator goi_chk u_goi_chk (.*);
